@@ rtl/bsw_pkg.sv @@
// Shared types and constants for the LSB-first bitstream writer.
`default_nettype none
package bsw_pkg;

  localparam int CAP_W          = 15;
  localparam int FIELD_W        = 32;
  localparam int CNT_W          = 6;
  localparam int USED_W         = 18;
  localparam int MAX_FIELD_BITS = 32;
  localparam int MAX_BYTES      = 5;
  localparam int BYTES_W        = 8 * MAX_BYTES;
  localparam int WORD_W         = BYTES_W + 8;

  localparam logic [CAP_W-1:0] CAP_RESET = 15'd16384;
  localparam logic [CAP_W:0]   ROOM_MIN  = 16'd4;
  localparam logic [CNT_W-1:0] FIELD_LIMIT =
    CNT_W'((MAX_FIELD_BITS < FIELD_W) ? MAX_FIELD_BITS : FIELD_W);

  localparam logic [1:0] FUNC_KEYED  = 2'd0;
  localparam logic [1:0] FUNC_DELTA  = 2'd1;
  localparam logic [1:0] FUNC_FINISH = 2'd2;
  localparam logic [1:0] FUNC_NONE   = 2'd3;

  typedef struct packed {
    logic [BYTES_W-1:0] bytes;
    logic [2:0]         count;
    logic               ovf;
    logic               fin;
    logic               fin_valid;
    logic [USED_W-1:0]  used;
  } qent_t;

endpackage
`default_nettype wire

@@ rtl/bsw_front.sv @@
// Front end: accepts requests, packs field bits and tracks stream state.
`default_nettype none
module bsw_front (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [bsw_pkg::CAP_W-1:0]  capacity,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [1:0]                 func,
  input  wire logic [bsw_pkg::FIELD_W-1:0] value,
  input  wire logic [bsw_pkg::FIELD_W-1:0] key,
  input  wire logic [bsw_pkg::FIELD_W-1:0] old_value,
  input  wire logic [bsw_pkg::CNT_W-1:0]  bit_count,
  output logic                            push,
  output bsw_pkg::qent_t                  push_ent,
  input  wire logic                       full
);
  import bsw_pkg::*;

  logic [7:0]       partial;
  logic [2:0]       offset;
  logic [CAP_W-1:0] started;
  logic             ovf;

  logic [7:0]       partial_next;
  logic [2:0]       offset_next;
  logic [CAP_W-1:0] started_next;
  logic             ovf_next;

  logic               accept;
  logic               is_write;
  logic               is_delta;
  logic               is_finish;
  logic               same;
  logic [CNT_W-1:0]   cnt_eff;
  logic [63:0]        mask64;
  logic               one_drop;
  logic               bit_len;
  logic [CAP_W-1:0]   started_mid;
  logic [CAP_W:0]     room;
  logic               do_keyed;
  logic               keyed_ok;
  logic [FIELD_W-1:0] field;
  logic [FIELD_W:0]   bits;
  logic [CNT_W-1:0]   len_total;
  logic [WORD_W-1:0]  word;
  logic [CNT_W-1:0]   total;
  logic [CNT_W-1:0]   total_up;
  logic [2:0]         nbytes;
  logic [2:0]         begun;
  logic [USED_W-1:0]  used;

  always_comb begin
    accept    = in_valid && !full;
    in_stall  = full;
    is_delta  = (func == FUNC_DELTA);
    is_finish = (func == FUNC_FINISH);
    is_write  = (func == FUNC_KEYED) || is_delta;
    same      = (old_value == value);

    cnt_eff = (bit_count > FIELD_LIMIT) ? FIELD_LIMIT : bit_count;
    mask64  = ~({64{1'b1}} << cnt_eff);

    one_drop    = is_delta && (offset == 3'd0) && (started >= capacity);
    bit_len     = is_delta && !one_drop;
    started_mid = started + CAP_W'(bit_len && (offset == 3'd0));

    room     = {1'b0, capacity} - {1'b0, started_mid};
    do_keyed = (func == FUNC_KEYED) || (is_delta && !same);
    keyed_ok = !room[CAP_W] && (room >= ROOM_MIN);

    field = (do_keyed && keyed_ok) ? ((value ^ key) & mask64[FIELD_W-1:0]) : '0;
    bits  = bit_len ? {field, !same} : {1'b0, field};
    len_total = CNT_W'(bit_len) + ((do_keyed && keyed_ok) ? cnt_eff : '0);

    word     = {{(WORD_W-8){1'b0}}, partial} | (WORD_W'(bits) << offset);
    total    = CNT_W'(offset) + len_total;
    total_up = total + CNT_W'(7);
    nbytes   = total[5:3];
    begun    = total_up[5:3] - 3'(offset != 3'd0);

    used = {started, 3'b000} - ((offset == 3'd0) ? '0 : USED_W'(4'd8 - {1'b0, offset}));

    partial_next = partial;
    offset_next  = offset;
    started_next = started;
    ovf_next     = ovf;
    if (is_finish) begin
      partial_next = '0;
      offset_next  = '0;
      started_next = '0;
      ovf_next     = 1'b0;
    end else if (is_write) begin
      partial_next = 8'(word >> {nbytes, 3'b000});
      offset_next  = total[2:0];
      started_next = started + CAP_W'(begun);
      ovf_next     = ovf | one_drop | (do_keyed && !keyed_ok);
    end

    push = accept && (is_finish || (is_write && (nbytes != 3'd0)));
    push_ent.bytes     = is_finish ? BYTES_W'(partial) : word[BYTES_W-1:0];
    push_ent.count     = is_finish ? 3'd1 : nbytes;
    push_ent.ovf       = is_finish ? ovf : ovf_next;
    push_ent.fin       = is_finish;
    push_ent.fin_valid = (offset != 3'd0);
    push_ent.used      = used;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial <= '0;
      offset  <= '0;
      started <= '0;
      ovf     <= 1'b0;
    end else if (accept) begin
      partial <= partial_next;
      offset  <= offset_next;
      started <= started_next;
      ovf     <= ovf_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/bsw_queue.sv @@
// Short queue of packed byte groups between front and back ends.
`default_nettype none
module bsw_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire bsw_pkg::qent_t push_ent,
  output logic                full,
  input  wire logic           pop,
  output bsw_pkg::qent_t      head,
  output logic                empty
);
  import bsw_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);

  qent_t             slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_QW-1:0] fill;
  logic              do_push;
  logic              do_pop;

  always_comb begin
    full    = (fill == CNT_QW'(DEPTH));
    empty   = (fill == '0);
    do_push = push && !full;
    do_pop  = pop && !empty;
    head    = slots[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_QW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_QW'(1);
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/bsw_back.sv @@
// Back end: serializes queued byte groups into the registered result port.
`default_nettype none
module bsw_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire bsw_pkg::qent_t             head,
  input  wire logic                       empty,
  output logic                            pop,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [7:0]                      out_byte,
  output logic                            byte_valid,
  output logic                            is_last,
  output logic                            overflow,
  output logic [bsw_pkg::USED_W-1:0]      used_bits
);
  import bsw_pkg::*;

  logic [2:0] idx;
  logic       load;
  logic       last;

  always_comb begin
    load = !empty && (!out_valid || !out_stall);
    last = (idx == (head.count - 3'd1));
    pop  = load && last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= last ? 3'd0 : idx + 3'd1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte   <= 8'(head.bytes >> {idx, 3'b000});
      byte_valid <= head.fin ? head.fin_valid : 1'b1;
      is_last    <= last;
      overflow   <= head.ovf;
      used_bits  <= head.fin ? head.used : '0;
    end
  end

endmodule
`default_nettype wire

@@ rtl/lsb_first_bitstream_writer.sv @@
// Top level of the LSB-first bitstream writer.
//
//  channel   direction  handshake             payload
//  request   in         in_valid / in_stall   func value key old_value bit_count
//  result    out        out_valid / out_stall out_byte byte_valid is_last overflow used_bits
//  config    in         cfg_we                cfg_data (capacity in bytes)
//
// A request is taken while in_stall is low; the front end packs its bits at once.
// Each request yields zero to five results, one per cycle from the back end while
// out_stall is low, one result for each byte that the request completes.
// The queue of QUEUE_DEPTH entries lets requests enter while results stall.
// Reset is synchronous; capacity returns to 16384 and stream state clears.
`default_nettype none
module lsb_first_bitstream_writer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [bsw_pkg::CAP_W-1:0]   cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  func,
  input  wire logic [bsw_pkg::FIELD_W-1:0] value,
  input  wire logic [bsw_pkg::FIELD_W-1:0] key,
  input  wire logic [bsw_pkg::FIELD_W-1:0] old_value,
  input  wire logic [bsw_pkg::CNT_W-1:0]   bit_count,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [7:0]                       out_byte,
  output logic                             byte_valid,
  output logic                             is_last,
  output logic                             overflow,
  output logic [bsw_pkg::USED_W-1:0]       used_bits
);
  import bsw_pkg::*;

  logic [CAP_W-1:0] capacity;
  logic             q_push;
  qent_t            q_push_ent;
  logic             q_full;
  logic             q_pop;
  qent_t            q_head;
  logic             q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  bsw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .capacity  (capacity),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .value     (value),
    .key       (key),
    .old_value (old_value),
    .bit_count (bit_count),
    .push      (q_push),
    .push_ent  (q_push_ent),
    .full      (q_full)
  );

  bsw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_ent (q_push_ent),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  bsw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .empty      (q_empty),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .is_last    (is_last),
    .overflow   (overflow),
    .used_bits  (used_bits)
  );

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the LSB-first bitstream writer.
`timescale 1ns / 100ps
module tb_top;
  import bsw_pkg::*;

  localparam int SETTLE     = 16;
  localparam int IDLE_LIMIT = 4000;
  localparam int PHASES     = 8;
  localparam int PER_PHASE  = 50;

  typedef struct packed {
    logic [7:0]        data;
    logic              vld;
    logic              last;
    logic              ovf;
    logic [USED_W-1:0] used;
  } stream_res_t;

  typedef enum logic {ROW_REQ, ROW_CAP} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [1:0]        fn;
    logic [FIELD_W-1:0] val;
    logic [FIELD_W-1:0] xkey;
    logic [FIELD_W-1:0] prev;
    logic [CNT_W-1:0]  cnt;
    logic              fixed;
    stream_res_t       want;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [CAP_W-1:0]    cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          func = FUNC_KEYED;
  logic [FIELD_W-1:0]  value = '0;
  logic [FIELD_W-1:0]  key = '0;
  logic [FIELD_W-1:0]  old_value = '0;
  logic [CNT_W-1:0]    bit_count = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [7:0]          out_byte;
  logic                byte_valid;
  logic                is_last;
  logic                overflow;
  logic [USED_W-1:0]   used_bits;

  logic                row_fixed = 1'b0;
  stream_res_t         row_want = '0;

  logic [7:0]          st_byte = '0;
  logic [2:0]          st_off = '0;
  logic [CAP_W-1:0]    st_started = '0;
  logic                st_ovf = 1'b0;
  logic [CAP_W-1:0]    st_cap = CAP_RESET;
  logic [7:0]          done_bytes[$];
  stream_res_t         step_out[$];
  stream_res_t         exp_stream[$];

  int errors = 0;
  int n_req = 0;
  int n_fin = 0;
  int n_out = 0;
  int n_ovf_out = 0;
  int n_caps = 0;
  int stall_left = 0;
  int stall_pct = 0;
  int quiet = 0;
  int burst_left = 0;
  bit pace_on = 1'b1;

  lsb_first_bitstream_writer u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .func(func), .value(value),
    .key(key), .old_value(old_value), .bit_count(bit_count),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
    .byte_valid(byte_valid), .is_last(is_last), .overflow(overflow),
    .used_bits(used_bits)
  );

  always #6 clk = ~clk;

  function automatic void put_bit(logic b);
    if (st_off == 3'd0) begin
      st_started = st_started + 1'b1;
      st_byte = 8'h00;
    end
    st_byte[st_off] = b;
    st_off = st_off + 3'd1;
    if (st_off == 3'd0) done_bytes.push_back(st_byte);
  endfunction

  function automatic void put_one(logic b);
    if (st_off == 3'd0 && st_started >= st_cap) st_ovf = 1'b1;
    else put_bit(b);
  endfunction

  function automatic void put_field(logic [FIELD_W-1:0] bits, logic [CNT_W-1:0] n);
    int len;
    if (st_started > st_cap || int'(st_cap) - int'(st_started) < int'(ROOM_MIN)) begin
      st_ovf = 1'b1;
      return;
    end
    len = (int'(n) > MAX_FIELD_BITS) ? MAX_FIELD_BITS : int'(n);
    if (len > FIELD_W) len = FIELD_W;
    for (int i = 0; i < len; i++) put_bit(bits[i]);
  endfunction

  function automatic void pack_request(logic [1:0] fn, logic [FIELD_W-1:0] v,
                                       logic [FIELD_W-1:0] k, logic [FIELD_W-1:0] o,
                                       logic [CNT_W-1:0] n);
    int u;
    step_out.delete();
    done_bytes.delete();
    case (fn)
      FUNC_FINISH: begin
        u = 8 * int'(st_started) - ((8 - int'(st_off)) & 7);
        step_out.push_back('{(st_off != 3'd0) ? st_byte : 8'h00, st_off != 3'd0, 1'b1,
                             st_ovf, USED_W'(u)});
        st_byte = '0;
        st_off = '0;
        st_started = '0;
        st_ovf = 1'b0;
      end
      FUNC_KEYED: put_field(v ^ k, n);
      FUNC_DELTA: begin
        if (o == v) begin
          put_one(1'b0);
        end else begin
          put_one(1'b1);
          put_field(v ^ k, n);
        end
      end
      default: ;
    endcase
    foreach (done_bytes[i])
      step_out.push_back('{done_bytes[i], 1'b1, i == done_bytes.size() - 1, st_ovf, '0});
  endfunction

  always @(posedge clk) begin : check_stream
    stream_res_t got;
    stream_res_t want;
    if (!rst) begin
      if (in_valid && in_stall === 1'b0) begin
        pack_request(func, value, key, old_value, bit_count);
        if (func != FUNC_NONE) n_req++;
        if (func == FUNC_FINISH) n_fin++;
        if (row_fixed) exp_stream.push_back(row_want);
        else foreach (step_out[i]) exp_stream.push_back(step_out[i]);
      end
      if (out_valid && out_stall === 1'b0) begin
        got = '{out_byte, byte_valid, is_last, overflow, used_bits};
        n_out++;
        if (overflow === 1'b1) n_ovf_out++;
        if (exp_stream.size() == 0) begin
          $error("unexpected result: out_byte %h is_last %b", out_byte, is_last);
          errors++;
        end else begin
          want = exp_stream.pop_front();
          if (got.data !== want.data) begin
            $error("out_byte: expected %h, got %h", want.data, got.data);
            errors++;
          end
          if (got.vld !== want.vld) begin
            $error("byte_valid: expected %b, got %b", want.vld, got.vld);
            errors++;
          end
          if (got.last !== want.last) begin
            $error("is_last: expected %b, got %b", want.last, got.last);
            errors++;
          end
          if (got.ovf !== want.ovf) begin
            $error("overflow: expected %b, got %b", want.ovf, got.ovf);
            errors++;
          end
          if (got.used !== want.used) begin
            $error("used_bits: expected %0d, got %0d", want.used, got.used);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_stall === 1'b0) || (out_valid && out_stall === 1'b0)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet == IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_left <= $urandom_range(8, 80);
      case ($urandom_range(0, 3))
        0: stall_pct <= 0;
        1: stall_pct <= 25;
        2: stall_pct <= 60;
        default: stall_pct <= 90;
      endcase
    end else begin
      stall_left <= stall_left - 1;
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  task automatic send_req(logic [1:0] fn, logic [FIELD_W-1:0] v, logic [FIELD_W-1:0] k,
                          logic [FIELD_W-1:0] o, logic [CNT_W-1:0] n, logic fixed,
                          stream_res_t want);
    func <= fn;
    value <= v;
    key <= k;
    old_value <= o;
    bit_count <= n;
    row_fixed <= fixed;
    row_want <= want;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic pace();
    if (!pace_on) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 9)) @(posedge clk);
    burst_left = $urandom_range(0, 20);
  endtask

  task automatic drain_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (exp_stream.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] c);
    drain_idle();
    cfg_we <= 1'b1;
    cfg_data <= c;
    @(posedge clk);
    cfg_we <= 1'b0;
    st_cap = c;
    n_caps++;
  endtask

  function automatic dir_row_t req_row(logic [1:0] fn, logic [FIELD_W-1:0] v,
                                       logic [FIELD_W-1:0] k, logic [FIELD_W-1:0] o,
                                       logic [CNT_W-1:0] n);
    dir_row_t r;
    r.kind = ROW_REQ;
    r.fn = fn;
    r.val = v;
    r.xkey = k;
    r.prev = o;
    r.cnt = n;
    r.fixed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic dir_row_t fixed_row(logic [1:0] fn, logic [FIELD_W-1:0] v,
                                         logic [CNT_W-1:0] n, logic [7:0] data,
                                         logic vld, logic ovf, logic [USED_W-1:0] used);
    dir_row_t r;
    r = req_row(fn, v, '0, '0, n);
    r.fixed = 1'b1;
    r.want = '{data, vld, 1'b1, ovf, used};
    return r;
  endfunction

  function automatic dir_row_t cap_row(logic [CAP_W-1:0] c);
    dir_row_t r;
    r = req_row(FUNC_NONE, FIELD_W'(c), '0, '0, '0);
    r.kind = ROW_CAP;
    return r;
  endfunction

  initial begin
    dir_row_t dir_rows[$];
    int cap_plan[PHASES];
    int pick;
    int n;
    int total;
    logic [1:0] fn;
    logic [FIELD_W-1:0] v;
    logic [FIELD_W-1:0] k;
    logic [FIELD_W-1:0] o;
    logic [CNT_W-1:0] cnt;

    dir_rows.push_back(fixed_row(FUNC_FINISH, '0, '0, 8'h00, 1'b0, 1'b0, '0));
    dir_rows.push_back(fixed_row(FUNC_KEYED, 32'h0000_00FF, 6'd8, 8'hFF, 1'b1, 1'b0, '0));
    dir_rows.push_back(req_row(FUNC_KEYED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, 6'd32));
    dir_rows.push_back(req_row(FUNC_KEYED, 32'hFFFF_FFFF, '0, '0, 6'd0));
    dir_rows.push_back(req_row(FUNC_KEYED, 32'hA5A5_A5A5, 32'h5A5A_5A5A, '0, 6'd63));
    dir_rows.push_back(req_row(FUNC_DELTA, 32'h1234_5678, 32'h0F0F_0F0F, 32'h1234_5678,
                               6'd20));
    dir_rows.push_back(req_row(FUNC_DELTA, 32'h8000_0001, '0, 32'h0000_0001, 6'd32));
    dir_rows.push_back(req_row(FUNC_KEYED, 32'h0000_002D, '0, '0, 6'd6));
    dir_rows.push_back(req_row(FUNC_KEYED, 32'h0000_0055, '0, '0, 6'd7));
    dir_rows.push_back(req_row(FUNC_DELTA, 32'hDEAD_BEEF, 32'hFFFF_0000, '0, 6'd32));
    dir_rows.push_back(req_row(FUNC_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, 6'd63));
    dir_rows.push_back(req_row(FUNC_KEYED, 32'h0000_0005, '0, '0, 6'd3));
    dir_rows.push_back(req_row(FUNC_FINISH, '0, '0, '0, '0));
    dir_rows.push_back(fixed_row(FUNC_FINISH, '0, '0, 8'h00, 1'b0, 1'b0, '0));
    dir_rows.push_back(cap_row('0));
    dir_rows.push_back(req_row(FUNC_KEYED, 32'h0000_FFFF, '0, '0, 6'd16));
    dir_rows.push_back(req_row(FUNC_DELTA, 32'h7, '0, 32'h7, 6'd8));
    dir_rows.push_back(fixed_row(FUNC_FINISH, '0, '0, 8'h00, 1'b0, 1'b1, '0));
    dir_rows.push_back(cap_row(15'd4));
    dir_rows.push_back(req_row(FUNC_KEYED, 32'hC3C3_3C3C, '0, '0, 6'd32));
    dir_rows.push_back(req_row(FUNC_KEYED, 32'h1, '0, '0, 6'd1));
    dir_rows.push_back(req_row(FUNC_DELTA, 32'h9, '0, 32'h9, 6'd4));
    dir_rows.push_back(fixed_row(FUNC_FINISH, '0, '0, 8'h00, 1'b0, 1'b1, 18'd32));
    dir_rows.push_back(cap_row(15'h7FFF));
    dir_rows.push_back(req_row(FUNC_KEYED, 32'h0102_0304, 32'hFFFF_FFFF, '0, 6'd32));
    dir_rows.push_back(cap_row(15'd2));
    dir_rows.push_back(req_row(FUNC_KEYED, 32'hFF, '0, '0, 6'd8));
    dir_rows.push_back(req_row(FUNC_DELTA, 32'h1, '0, 32'h2, 6'd8));
    dir_rows.push_back(fixed_row(FUNC_FINISH, '0, '0, 8'h00, 1'b0, 1'b1, 18'd32));

    cap_plan = '{32767, 0, $urandom_range(1, 8), 16384, $urandom_range(4, 40),
                 $urandom_range(0, 32767), 5, 16384};

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CAP) begin
        set_capacity(dir_rows[i].val[CAP_W-1:0]);
      end else begin
        send_req(dir_rows[i].fn, dir_rows[i].val, dir_rows[i].xkey, dir_rows[i].prev,
                 dir_rows[i].cnt, dir_rows[i].fixed, dir_rows[i].want);
        pace();
      end
    end

    total = 0;
    for (int ph = 0; ph < PHASES; ph++) begin
      set_capacity(CAP_W'(cap_plan[ph]));
      pace_on = (ph != 2);
      n = 0;
      while (n < PER_PHASE) begin
        pick = $urandom_range(0, 99);
        fn = (pick < 4) ? FUNC_NONE : (pick < 12) ? FUNC_FINISH :
             (pick < 56) ? FUNC_KEYED : FUNC_DELTA;
        v = $urandom();
        k = ($urandom_range(0, 3) == 0) ? '0 : $urandom();
        case ($urandom_range(0, 3))
          0: o = v;
          1: o = v ^ (32'd1 << $urandom_range(0, 31));
          default: o = $urandom();
        endcase
        cnt = ($urandom_range(0, 6) == 0) ? CNT_W'($urandom_range(0, 63)) :
                                            CNT_W'($urandom_range(1, 32));
        send_req(fn, v, k, o, cnt, 1'b0, '0);
        pace();
        if (fn != FUNC_NONE) begin
          n++;
          total++;
        end
        if (total == 200 && fn != FUNC_NONE) drain_idle();
      end
    end

    drain_idle();
    $display("Checked %0d results from %0d requests (%0d finishes) over %0d capacity writes",
             n_out, n_req, n_fin, n_caps);
    $display("Overflow flag was set on %0d of the checked results", n_ovf_out);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
